// File: rtl/core/bsl_pkg.sv
// Shared types and constants for the bounded sequence unit.
// Field widths, request codes and the run tracker control group.
// No dependencies; compile first.
package bsl_pkg;

  localparam int REQ_W = 3;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int CNT_OUT_W = 6;

  localparam logic [REQ_W-1:0] REQ_APPEND  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REPLACE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RUN     = 3'd6;

  typedef struct packed {
    logic init;   // restart tracking
    logic load;   // capture the element on the read port as previous
    logic step;   // close out one element index
    logic tail;   // the index has no successor
  } run_ctl_t;

endpackage

// File: rtl/core/bsl_if.sv
// Request and response channel interfaces for the bounded sequence unit.
// Depends on bsl_pkg for field widths.
interface bsl_req_if;
  logic                             valid;
  logic                             ready;
  logic [bsl_pkg::REQ_W-1:0]        req_type;
  logic [bsl_pkg::POS_W-1:0]        position;
  logic signed [bsl_pkg::VAL_W-1:0] value;

  modport source (output valid, output req_type, output position, output value, input ready);
  modport sink   (input valid, input req_type, input position, input value, output ready);
endinterface

interface bsl_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bsl_pkg::VAL_W-1:0]     read_value;
  logic [bsl_pkg::CNT_OUT_W-1:0]        run_start;
  logic [bsl_pkg::CNT_OUT_W-1:0]        element_count;
  logic                                 is_empty;
  logic                                 is_full;
  logic                                 status;

  modport source (output valid, output read_value, output run_start, output element_count,
                  output is_empty, output is_full, output status, input ready);
  modport sink   (input valid, input read_value, input run_start, input element_count,
                  input is_empty, input is_full, input status, output ready);
endinterface

// File: rtl/core/bounded_sequence_with_longest_run_unit.sv
// Bounded sequence unit with longest-run query: top level.
// Depends on bsl_pkg, bsl_if (bsl_req_if, bsl_rsp_if), bsl_ram and bsl_run.
//
// Usage: one request beat on req (append, insert, remove, replace, read,
// clear, longest-run query) yields exactly one response beat on rsp, which
// carries the read value, the run start, the element count after the request,
// the empty and full flags and a reject status.
// Response timing, with p = position: append, replace, clear, rejected
//   requests, insert at the end, remove of the last element and a query of
//   an empty list: response is valid the cycle after the request beat.
//   read: S_RD_WAIT.  insert: S_INS shifts elements p and up, S_INS_PUT.
//   remove: S_REM shifts the tail.  query: S_SCAN, S_SCAN_END, S_RUN_OUT.
// The shifts and the scan walk the single read port of the element store,
// one element per cycle; the run tracker does one compare per element.
// Only one request is in work at a time; req.ready is low until it finishes.
// A finished response sits in an output register; the next request beat is
// taken in the same cycle that the waiting response beat leaves. While rsp
// is stalled the response holds and no new request is taken.
// Reset clears the element count and the control state; the store itself
// is not cleared, since entries at or above the count are never read.
module bounded_sequence_with_longest_run_unit #(
  parameter int CAPACITY = 32
) (
  input  logic          clk,
  input  logic          rst,
  bsl_req_if.sink       req,
  bsl_rsp_if.source     rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = (CW > bsl_pkg::POS_W) ? CW : bsl_pkg::POS_W;
  localparam int OW = bsl_pkg::CNT_OUT_W;
  localparam int VW = bsl_pkg::VAL_W;

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS     = 3'd1;  // move one element right per cycle
  localparam logic [2:0] S_INS_PUT = 3'd2;  // drop the new value into the gap
  localparam logic [2:0] S_REM     = 3'd3;  // move one element left per cycle
  localparam logic [2:0] S_RD_WAIT = 3'd4;  // wait for registered read data
  localparam logic [2:0] S_SCAN    = 3'd5;  // stream elements into the tracker
  localparam logic [2:0] S_SCAN_END = 3'd6; // close out the last element
  localparam logic [2:0] S_RUN_OUT = 3'd7;  // present the run start

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] w, w_next;        // shift write index
  logic [CW-1:0] k, k_next;        // scan index of data on the read port
  logic [CW-1:0] pos_q;
  logic [VW-1:0] val_q;

  // response register
  logic          o_valid;
  logic [VW-1:0] o_read;
  logic [OW-1:0] o_run;
  logic          o_st;

  // completion strobe and its payload
  logic          fin;
  logic [VW-1:0] fin_read;
  logic [OW-1:0] fin_run;
  logic          fin_st;

  // store ports
  logic          mem_we, mem_re;
  logic [CW-1:0] mem_wa, mem_ra;
  logic [VW-1:0] mem_wd, mem_rd;

  // run tracker
  bsl_pkg::run_ctl_t run_ctl;
  logic [CW-1:0]     run_idx;
  logic [CW-1:0]     best_start;

  logic          accept;
  logic          full;
  logic [PW-1:0] pos_x, cnt_x;
  logic [CW:0]   w_plus2, k_plus1;

  assign req.ready = (state == S_IDLE) && (!o_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(CAPACITY));
  assign pos_x     = PW'(req.position);
  assign cnt_x     = PW'(count);
  assign w_plus2   = {1'b0, w} + (CW + 1)'(2);
  assign k_plus1   = {1'b0, k} + (CW + 1)'(1);

  bsl_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk(clk),
    .we (mem_we),
    .wa (mem_wa[AW-1:0]),
    .wd (mem_wd),
    .re (mem_re),
    .ra (mem_ra[AW-1:0]),
    .rd (mem_rd)
  );

  bsl_run #(
    .CW(CW)
  ) u_run (
    .clk       (clk),
    .ctl       (run_ctl),
    .init_start(count),
    .idx       (run_idx),
    .data      (mem_rd),
    .best_start(best_start)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    w_next     = w;
    k_next     = k;
    mem_we     = 1'b0;
    mem_wa     = w;
    mem_wd     = mem_rd;
    mem_re     = 1'b0;
    mem_ra     = w;
    fin        = 1'b0;
    fin_read   = '0;
    fin_run    = '0;
    fin_st     = 1'b0;
    run_ctl    = '0;
    run_idx    = k - CW'(1);

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.req_type)
            bsl_pkg::REQ_APPEND: begin
              fin = 1'b1;
              if (full) begin
                fin_st = 1'b1;
              end else begin
                mem_we     = 1'b1;
                mem_wa     = count;
                mem_wd     = req.value;
                count_next = count + CW'(1);
              end
            end
            bsl_pkg::REQ_INSERT: begin
              if (full || pos_x > cnt_x) begin
                fin    = 1'b1;
                fin_st = 1'b1;
              end else if (pos_x == cnt_x) begin
                // insert at the end acts as append
                fin        = 1'b1;
                mem_we     = 1'b1;
                mem_wa     = count;
                mem_wd     = req.value;
                count_next = count + CW'(1);
              end else begin
                mem_re     = 1'b1;
                mem_ra     = count - CW'(1);
                w_next     = count;
                state_next = S_INS;
              end
            end
            bsl_pkg::REQ_REMOVE: begin
              if (pos_x >= cnt_x) begin
                fin    = 1'b1;
                fin_st = 1'b1;
              end else if (pos_x == cnt_x - PW'(1)) begin
                // last element: nothing to move
                fin        = 1'b1;
                count_next = count - CW'(1);
              end else begin
                mem_re     = 1'b1;
                mem_ra     = pos_x[CW-1:0] + CW'(1);
                w_next     = pos_x[CW-1:0];
                state_next = S_REM;
              end
            end
            bsl_pkg::REQ_REPLACE: begin
              fin = 1'b1;
              if (pos_x >= cnt_x) begin
                fin_st = 1'b1;
              end else begin
                mem_we = 1'b1;
                mem_wa = pos_x[CW-1:0];
                mem_wd = req.value;
              end
            end
            bsl_pkg::REQ_READ: begin
              if (pos_x >= cnt_x) begin
                fin    = 1'b1;
                fin_st = 1'b1;
              end else begin
                mem_re     = 1'b1;
                mem_ra     = pos_x[CW-1:0];
                state_next = S_RD_WAIT;
              end
            end
            bsl_pkg::REQ_CLEAR: begin
              fin        = 1'b1;
              count_next = '0;
            end
            bsl_pkg::REQ_RUN: begin
              if (count == '0) begin
                // empty list: run start is the count, zero
                fin = 1'b1;
              end else begin
                run_ctl.init = 1'b1;
                mem_re       = 1'b1;
                mem_ra       = '0;
                k_next       = '0;
                state_next   = S_SCAN;
              end
            end
            default: begin
              fin    = 1'b1;
              fin_st = 1'b1;
            end
          endcase
        end
      end

      S_INS: begin
        // read data is element w-1; store it one place right
        mem_we = 1'b1;
        mem_wa = w;
        mem_wd = mem_rd;
        if (w - CW'(1) > pos_q) begin
          mem_re = 1'b1;
          mem_ra = w - CW'(2);
          w_next = w - CW'(1);
        end else begin
          state_next = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        mem_we     = 1'b1;
        mem_wa     = pos_q;
        mem_wd     = val_q;
        count_next = count + CW'(1);
        fin        = 1'b1;
        state_next = S_IDLE;
      end

      S_REM: begin
        // read data is element w+1; store it one place left
        mem_we = 1'b1;
        mem_wa = w;
        mem_wd = mem_rd;
        if (w_plus2 < {1'b0, count}) begin
          mem_re = 1'b1;
          mem_ra = w_plus2[CW-1:0];
          w_next = w + CW'(1);
        end else begin
          count_next = count - CW'(1);
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_RD_WAIT: begin
        fin        = 1'b1;
        fin_read   = mem_rd;
        state_next = S_IDLE;
      end

      S_SCAN: begin
        // element k is on the read port; it decides index k-1
        run_ctl.load = 1'b1;
        run_ctl.step = (k != '0);
        run_idx      = k - CW'(1);
        if (k_plus1 < {1'b0, count}) begin
          mem_re = 1'b1;
          mem_ra = k_plus1[CW-1:0];
          k_next = k_plus1[CW-1:0];
        end else begin
          state_next = S_SCAN_END;
        end
      end

      S_SCAN_END: begin
        run_ctl.step = 1'b1;
        run_ctl.tail = 1'b1;
        run_idx      = count - CW'(1);
        state_next   = S_RUN_OUT;
      end

      S_RUN_OUT: begin
        fin        = 1'b1;
        fin_run    = OW'(best_start);
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      // load a finished response; otherwise drop the beat once taken
      if (fin) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    w <= w_next;
    k <= k_next;
    if (accept) begin
      pos_q <= pos_x[CW-1:0];
      val_q <= req.value;
    end
    if (fin) begin
      o_read <= fin_read;
      o_run  <= fin_run;
      o_st   <= fin_st;
    end
  end

  // count only moves at the beat that also loads the response, so the
  // status fields can follow the count register directly
  assign rsp.valid         = o_valid;
  assign rsp.read_value    = o_read;
  assign rsp.run_start     = o_run;
  assign rsp.element_count = OW'(count);
  assign rsp.is_empty      = (count == '0);
  assign rsp.is_full       = full;
  assign rsp.status        = o_st;

endmodule

// File: rtl/core/bsl_ram.sv
// Element store: one write port, one read port with registered data.
// Depends on bsl_pkg for the element width.
module bsl_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             wa,
  input  logic [bsl_pkg::VAL_W-1:0] wd,
  input  logic                      re,
  input  logic [AW-1:0]             ra,
  output logic [bsl_pkg::VAL_W-1:0] rd
);

  logic [bsl_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

// File: rtl/core/bsl_run.sv
// Longest-run tracker: one equality compare per element streamed from the store.
// Depends on bsl_pkg for run_ctl_t and the element width.
module bsl_run #(
  parameter int CW = 6
) (
  input  logic                      clk,
  input  bsl_pkg::run_ctl_t         ctl,
  input  logic [CW-1:0]             init_start,
  input  logic [CW-1:0]             idx,
  input  logic [bsl_pkg::VAL_W-1:0] data,
  output logic [CW-1:0]             best_start
);

  logic [bsl_pkg::VAL_W-1:0] prev;
  logic [CW-1:0]             cur;
  logic [CW-1:0]             best_len;
  logic                      eq;

  assign eq = !ctl.tail && (data == prev);

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      cur        <= '0;
      best_len   <= '0;
      best_start <= init_start;
    end else if (ctl.step) begin
      if (eq) begin
        cur <= cur + CW'(1);
      end else begin
        // close the current run; strictly longer wins, so the earliest stays
        if (cur > best_len) begin
          best_len   <= cur;
          best_start <= idx - cur;
        end
        cur <= '0;
      end
    end
    if (ctl.load) begin
      prev <= data;
    end
  end

endmodule

// File: test/bounded_sequence_with_longest_run_unit_tb.sv
// Self-checking bench for bounded_sequence_with_longest_run_unit: directed table, random traffic.
// Every response is checked against an in-bench list model or a typed-in directed response.
// Depends on bsl_pkg, bsl_if and the RTL of the unit.
`timescale 1ns / 1ps

module bounded_sequence_with_longest_run_unit_tb;

  localparam int REQ_W     = bsl_pkg::REQ_W;
  localparam int POS_W     = bsl_pkg::POS_W;
  localparam int VAL_W     = bsl_pkg::VAL_W;
  localparam int CNT_OUT_W = bsl_pkg::CNT_OUT_W;

  localparam int CAPACITY      = 32;
  localparam int ITEMS_PER_SET = 667;    // three traffic sets, ~2000 requests in all
  localparam int SETTLE_CYCLES = 40;     // longer than the slowest request (scan of a full list)

  // One response beat, laid out like the rsp channel.
  typedef struct packed {
    logic signed [VAL_W-1:0]   read_value;
    logic [CNT_OUT_W-1:0]      run_start;
    logic [CNT_OUT_W-1:0]      element_count;
    logic                      is_empty;
    logic                      is_full;
    logic                      status;
  } seq_rsp_t;

  // Directed row: a request, repeated reps times, with an optional typed-in response.
  typedef struct packed {
    logic [REQ_W-1:0]        op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    logic [5:0]              reps;
    logic                    fixed_exp;
    seq_rsp_t                want;
  } dir_row_t;

  localparam int DIR_ROWS = 35;

  // Responses typed in here come straight from the list contents at that point:
  // {read_value, run_start, count, empty, full, status}.
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // empty list right after reset: position requests reject, scan returns the count
    '{bsl_pkg::REQ_READ, 6'd0, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd0, 1'b1, 1'b0, 1'b1}},
    '{bsl_pkg::REQ_RUN, 6'd0, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd0, 1'b1, 1'b0, 1'b0}},
    '{bsl_pkg::REQ_REMOVE, 6'd0, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd0, 1'b1, 1'b0, 1'b1}},
    '{bsl_pkg::REQ_REPLACE, 6'd0, 32'sd9, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd0, 1'b1, 1'b0, 1'b1}},
    '{bsl_pkg::REQ_INSERT, 6'd1, 32'sd5, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd0, 1'b1, 1'b0, 1'b1}},
    '{bsl_pkg::REQ_CLEAR, 6'd0, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd0, 1'b1, 1'b0, 1'b0}},
    // insert at the count behaves as an append; value extremes
    '{bsl_pkg::REQ_INSERT, 6'd0, 32'sh7FFF_FFFF, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd1, 1'b0, 1'b0, 1'b0}},
    '{bsl_pkg::REQ_APPEND, 6'd0, 32'sh8000_0000, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd2, 1'b0, 1'b0, 1'b0}},
    '{bsl_pkg::REQ_READ, 6'd0, 32'sd0, 6'd1, 1'b1,
      '{32'sh7FFF_FFFF, 6'd0, 6'd2, 1'b0, 1'b0, 1'b0}},
    '{bsl_pkg::REQ_READ, 6'd1, 32'sd0, 6'd1, 1'b1,
      '{32'sh8000_0000, 6'd0, 6'd2, 1'b0, 1'b0, 1'b0}},
    '{bsl_pkg::REQ_READ, 6'd63, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd2, 1'b0, 1'b0, 1'b1}},
    // no adjacent pair yet: scan reports the count
    '{bsl_pkg::REQ_RUN, 6'd0, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd2, 6'd2, 1'b0, 1'b0, 1'b0}},
    '{bsl_pkg::REQ_INSERT, 6'd1, 32'sh8000_0000, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd3, 1'b0, 1'b0, 1'b0}},
    '{bsl_pkg::REQ_RUN, 6'd0, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd1, 6'd3, 1'b0, 1'b0, 1'b0}},
    // two runs of equal length: the earlier one wins
    '{bsl_pkg::REQ_INSERT, 6'd0, 32'sh7FFF_FFFF, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd4, 1'b0, 1'b0, 1'b0}},
    '{bsl_pkg::REQ_RUN, 6'd0, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd4, 1'b0, 1'b0, 1'b0}},
    '{bsl_pkg::REQ_REMOVE, 6'd0, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd3, 1'b0, 1'b0, 1'b0}},
    '{bsl_pkg::REQ_REPLACE, 6'd2, -32'sd1, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd3, 1'b0, 1'b0, 1'b0}},
    '{bsl_pkg::REQ_RUN, 6'd0, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd3, 6'd3, 1'b0, 1'b0, 1'b0}},
    // positions at and past the count
    '{bsl_pkg::REQ_REPLACE, 6'd3, 32'sd1, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd3, 1'b0, 1'b0, 1'b1}},
    '{bsl_pkg::REQ_REMOVE, 6'd3, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd3, 1'b0, 1'b0, 1'b1}},
    '{bsl_pkg::REQ_REMOVE, 6'd2, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd2, 1'b0, 1'b0, 1'b0}},
    '{bsl_pkg::REQ_INSERT, 6'd3, 32'sd1, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd2, 1'b0, 1'b0, 1'b1}},
    '{bsl_pkg::REQ_CLEAR, 6'd0, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd0, 1'b1, 1'b0, 1'b0}},
    // fill to capacity with one value, then hit the full-list cases
    '{bsl_pkg::REQ_APPEND, 6'd0, 32'sd0, 6'd32, 1'b0, '0},
    '{bsl_pkg::REQ_APPEND, 6'd0, 32'sd1, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd32, 1'b0, 1'b1, 1'b1}},
    '{bsl_pkg::REQ_INSERT, 6'd0, 32'sd1, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd32, 1'b0, 1'b1, 1'b1}},
    '{bsl_pkg::REQ_RUN, 6'd0, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd32, 1'b0, 1'b1, 1'b0}},
    '{bsl_pkg::REQ_READ, 6'd31, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd32, 1'b0, 1'b1, 1'b0}},
    '{bsl_pkg::REQ_REMOVE, 6'd0, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd31, 1'b0, 1'b0, 1'b0}},
    '{bsl_pkg::REQ_INSERT, 6'd31, 32'sd5, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd32, 1'b0, 1'b1, 1'b0}},
    '{bsl_pkg::REQ_RUN, 6'd0, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd32, 1'b0, 1'b1, 1'b0}},
    '{bsl_pkg::REQ_READ, 6'd31, 32'sd0, 6'd1, 1'b1,
      '{32'sd5, 6'd0, 6'd32, 1'b0, 1'b1, 1'b0}},
    '{bsl_pkg::REQ_REMOVE, 6'd31, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd31, 1'b0, 1'b0, 1'b0}},
    '{bsl_pkg::REQ_CLEAR, 6'd0, 32'sd0, 6'd1, 1'b1,
      '{32'sd0, 6'd0, 6'd0, 1'b1, 1'b0, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst;
  logic rsp_ready = 1'b0;

  bsl_req_if req_if ();
  bsl_rsp_if rsp_if ();

  assign rsp_if.ready = rsp_ready;

  bounded_sequence_with_longest_run_unit #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #1 clk = ~clk;

  // Shadow copy of the list, advanced once per accepted request beat.
  logic signed [VAL_W-1:0] shadow_list [CAPACITY];
  int                      shadow_len;

  // Responses still owed by the unit, oldest first.
  seq_rsp_t awaited_rsp [$];
  seq_rsp_t head_rsp;
  int       mismatches = 0;

  // Idle shaping: percent chance per cycle of a sender idle cycle before a
  // request, and of a receiver stall.
  int send_idle_pct = 6;
  int recv_stall_pct = 47;

  // Apply one request to the shadow list and return the response it owes.
  function automatic seq_rsp_t apply_request(input logic [REQ_W-1:0] op, input int pos,
                                             input logic signed [VAL_W-1:0] val);
    seq_rsp_t r;
    int       i;
    int       best_len;
    int       cur;
    r = '0;
    case (op)
      bsl_pkg::REQ_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          r.status = 1'b1;
        end else begin
          shadow_list[shadow_len] = val;
          shadow_len++;
        end
      end
      bsl_pkg::REQ_INSERT: begin
        if (shadow_len >= CAPACITY || pos > shadow_len) begin
          r.status = 1'b1;
        end else begin
          for (i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = val;
          shadow_len++;
        end
      end
      bsl_pkg::REQ_REMOVE: begin
        if (pos >= shadow_len) begin
          r.status = 1'b1;
        end else begin
          for (i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      bsl_pkg::REQ_REPLACE: begin
        if (pos >= shadow_len) r.status = 1'b1;
        else shadow_list[pos] = val;
      end
      bsl_pkg::REQ_READ: begin
        if (pos >= shadow_len) r.status = 1'b1;
        else r.read_value = shadow_list[pos];
      end
      bsl_pkg::REQ_CLEAR: begin
        shadow_len = 0;
      end
      bsl_pkg::REQ_RUN: begin
        // Close out each run at its last index; only a strictly longer run
        // replaces the best, so ties keep the earliest start.
        best_len    = 0;
        cur         = 0;
        r.run_start = 6'(shadow_len);
        for (i = 0; i < shadow_len; i++) begin
          if (i + 1 < shadow_len && shadow_list[i+1] == shadow_list[i]) begin
            cur++;
          end else begin
            if (cur > best_len) begin
              best_len    = cur;
              r.run_start = 6'(i - cur);
            end
            cur = 0;
          end
        end
      end
      default: begin
        r.status = 1'b1;
      end
    endcase
    r.element_count = 6'(shadow_len);
    r.is_empty      = (shadow_len == 0);
    r.is_full       = (shadow_len == CAPACITY);
    return r;
  endfunction

  // Drive one request beat and hold it until accepted. Idle cycles may come
  // first; valid gets at most one assignment per time step.
  task automatic send_req(input logic [REQ_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic signed [VAL_W-1:0] val, input logic fixed_exp,
                          input seq_rsp_t want);
    seq_rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= op;
    req_if.position <= pos;
    req_if.value    <= val;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    // Beat taken at this edge: advance the shadow list in acceptance order.
    predicted = apply_request(op, int'(pos), val);
    awaited_rsp.push_back(fixed_exp ? want : predicted);
  endtask

  // Drop valid and hold until every owed response has arrived.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  // Response side: check each beat against the oldest owed response, then
  // pick the next cycle's ready. Outputs are read as they stood before the edge.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid === 1'b1 && rsp_ready) begin
      if (awaited_rsp.size() == 0) begin
        mismatches++;
        $display("%0t ns: response beat with no request outstanding, expected none, actual %h",
                 $time, {rsp_if.read_value, rsp_if.run_start, rsp_if.element_count,
                         rsp_if.is_empty, rsp_if.is_full, rsp_if.status});
      end else begin
        head_rsp = awaited_rsp.pop_front();
        report_field("read_value",    head_rsp.read_value,         rsp_if.read_value);
        report_field("run_start",     32'(head_rsp.run_start),     32'(rsp_if.run_start));
        report_field("element_count", 32'(head_rsp.element_count),
                     32'(rsp_if.element_count));
        report_field("is_empty",      32'(head_rsp.is_empty),      32'(rsp_if.is_empty));
        report_field("is_full",       32'(head_rsp.is_full),       32'(rsp_if.is_full));
        report_field("status",        32'(head_rsp.status),        32'(rsp_if.status));
      end
    end
    rsp_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin : stimulus
    logic [REQ_W-1:0]        op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    int                      pick;
    // Known values on every input, reset asserted, from the first step.
    rst             <= 1'b1;
    req_if.valid    <= 1'b0;
    req_if.req_type <= bsl_pkg::REQ_APPEND;
    req_if.position <= '0;
    req_if.value    <= '0;
    shadow_len = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table: empty list, extremes, rejects, ties, full list.
    for (int row = 0; row < DIR_ROWS; row++) begin
      for (int k = 0; k < DIR_TAB[row].reps; k++) begin
        send_req(DIR_TAB[row].op, DIR_TAB[row].pos, DIR_TAB[row].val,
                 DIR_TAB[row].fixed_exp, DIR_TAB[row].want);
      end
    end
    // Let the unit go fully idle once before random traffic.
    drain();

    // Random traffic in three sets: sender mostly busy / receiver stalling,
    // then the reverse, then no idling on either side.
    for (int set = 0; set < 3; set++) begin
      send_idle_pct  = (set == 0) ? 6 : (set == 1) ? 47 : 0;
      recv_stall_pct = (set == 0) ? 47 : (set == 1) ? 6 : 0;
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        // Growing requests outnumber shrinking ones so the list often reaches full;
        // scans are frequent, clears rare so long lists survive.
        pick = $urandom_range(99);
        if (pick < 25)      op = bsl_pkg::REQ_APPEND;
        else if (pick < 45) op = bsl_pkg::REQ_INSERT;
        else if (pick < 60) op = bsl_pkg::REQ_REMOVE;
        else if (pick < 70) op = bsl_pkg::REQ_REPLACE;
        else if (pick < 82) op = bsl_pkg::REQ_READ;
        else if (pick < 97) op = bsl_pkg::REQ_RUN;
        else                op = bsl_pkg::REQ_CLEAR;

        // Positions mostly within 0..count (count itself rejects for most
        // requests); now and then anywhere in the field.
        if ($urandom_range(9) == 0) pos = POS_W'($urandom_range(63));
        else pos = POS_W'($urandom_range(shadow_len));

        // Values from a narrow pool to build runs, plus extremes and full range.
        case ($urandom_range(4))
          0: val = $urandom;
          1: val = (shadow_len != 0) ? shadow_list[shadow_len-1] : 32'sd0;
          2: val = 32'($urandom_range(3));
          3: val = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          default: val = ~32'($urandom_range(2));
        endcase

        send_req(op, pos, val, 1'b0, '0);
        if (set == 1 && n == ITEMS_PER_SET / 2) drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("bounded_sequence_with_longest_run_unit test passed");
    end else begin
      $display("bounded_sequence_with_longest_run_unit test failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("bounded_sequence_with_longest_run_unit test failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bsl_pkg.sv
rtl/core/bsl_if.sv
rtl/core/bsl_ram.sv
rtl/core/bsl_run.sv
rtl/core/bounded_sequence_with_longest_run_unit.sv
test/bounded_sequence_with_longest_run_unit_tb.sv
